@@ src/rational_mul_div_reduce_assert.svh @@
// Assertion macros for the rational multiply/divide block.
// Used by the checker module; no other dependencies.
`ifndef RATIONAL_MUL_DIV_REDUCE_ASSERT_SVH
`define RATIONAL_MUL_DIV_REDUCE_ASSERT_SVH
`define RMD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/rmd_pkg.sv @@
// Package for the rational multiply/divide block: widths, types, op codes.
// No dependencies.
package rmd_pkg;
  localparam int OpW = 1;
  localparam int InW = 16;
  localparam int ResW = 32;
  localparam int QueueDepth = 2;
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic signed [InW-1:0] a_num;
    logic signed [InW-1:0] a_den;
    logic signed [InW-1:0] b_num;
    logic signed [InW-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [ResW-1:0] res_num;
    logic signed [ResW-1:0] res_den;
    logic zero_divisor;
  } out_item_t;

  typedef struct packed {
    logic signed [ResW-1:0] n;
    logic signed [ResW-1:0] d;
  } raw_pair_t;
endpackage

@@ src/rmd_if.sv @@
// Valid/ready channel interfaces for input and result items.
// Depends on rmd_pkg.
interface rmd_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [rmd_pkg::OpW-1:0] op;
  logic signed [rmd_pkg::InW-1:0] a_num;
  logic signed [rmd_pkg::InW-1:0] a_den;
  logic signed [rmd_pkg::InW-1:0] b_num;
  logic signed [rmd_pkg::InW-1:0] b_den;
  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rmd_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [rmd_pkg::ResW-1:0] res_num;
  logic signed [rmd_pkg::ResW-1:0] res_den;
  logic zero_divisor;
  modport source (output valid, res_num, res_den, zero_divisor, input ready);
  modport sink (input valid, res_num, res_den, zero_divisor, output ready);
endinterface

@@ src/rmd_front.sv @@
// Front end: accept an item, form the raw product pair, register it.
// Depends on rmd_pkg.
module rmd_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rmd_pkg::in_item_t in_item,
  output logic raw_valid,
  input  logic raw_ready,
  output rmd_pkg::raw_pair_t raw
);
  logic signed [rmd_pkg::InW-1:0] m0, m1;
  logic signed [rmd_pkg::ResW-1:0] p_n, p_d;

  always_comb begin
    m0 = (in_item.op == rmd_pkg::OP_DIV) ? in_item.b_den : in_item.b_num;
    m1 = (in_item.op == rmd_pkg::OP_DIV) ? in_item.b_num : in_item.b_den;
    p_n = 32'(in_item.a_num * m0);
    p_d = 32'(in_item.a_den * m1);
  end

  assign in_ready = !raw_valid || raw_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (in_ready) begin
      raw_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      raw.n <= p_n;
      raw.d <= p_d;
    end
  end
endmodule

@@ src/rmd_queue.sv @@
// Short FIFO between the front and back ends.
// Depends on rmd_pkg.
module rmd_queue #(
  parameter int Depth = rmd_pkg::QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  rmd_pkg::raw_pair_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output rmd_pkg::raw_pair_t rd_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  rmd_pkg::raw_pair_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic do_wr, do_rd;

  assign wr_ready = cnt != (AW+1)'(Depth);
  assign rd_valid = cnt != '0;
  assign rd_data = mem[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
    if (do_wr) mem[wp] <= wr_data;
  end
endmodule

@@ src/rmd_divu.sv @@
// Iterative signed truncating divider, one quotient bit a cycle.
// Depends on rmd_pkg.
module rmd_divu (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [rmd_pkg::ResW-1:0] dividend,
  input  logic signed [rmd_pkg::ResW-1:0] divisor,
  output logic done,
  output logic signed [rmd_pkg::ResW-1:0] quot,
  output logic signed [rmd_pkg::ResW-1:0] rem
);
  localparam int W = rmd_pkg::ResW;
  localparam int CW = $clog2(W);
  logic busy;
  logic [CW-1:0] cnt;
  logic [W-1:0] q, dv;
  logic [W:0] r;
  logic neg_q, neg_r;
  logic [W:0] r_sh;
  logic [W:0] r_sub;

  always_comb begin
    r_sh = {r[W-1:0], q[W-1]};
    r_sub = r_sh - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        q <= dividend[W-1] ? W'(-dividend) : W'(dividend);
        dv <= divisor[W-1] ? W'(-divisor) : W'(divisor);
        r <= '0;
        neg_q <= dividend[W-1] ^ divisor[W-1];
        neg_r <= dividend[W-1];
      end else if (busy) begin
        if (!r_sub[W]) begin
          r <= r_sub;
          q <= {q[W-2:0], 1'b1};
        end else begin
          r <= r_sh;
          q <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg_q ? -$signed(q) : $signed(q);
  assign rem = neg_r ? -$signed(r[W-1:0]) : $signed(r[W-1:0]);
endmodule

@@ src/rmd_back.sv @@
// Back end: Euclid loop on the shared divider, then two divisions by g (skipped if the denominator is zero).
// Depends on rmd_pkg and rmd_divu.
module rmd_back (
  input  logic clk,
  input  logic rst,
  input  logic raw_valid,
  output logic raw_ready,
  input  rmd_pkg::raw_pair_t raw,
  output logic res_valid,
  input  logic res_ready,
  output rmd_pkg::out_item_t res
);
  typedef enum logic [2:0] {
    IDLE, EUC_GO, EUC_WAIT, DN_WAIT, DD_WAIT, OUT
  } state_t;
  state_t state;
  logic signed [rmd_pkg::ResW-1:0] x, y, n, d, qn;
  logic dv_start, dv_done;
  logic signed [rmd_pkg::ResW-1:0] dv_a, dv_b, dv_q, dv_r;

  rmd_divu u_div (
    .clk, .rst, .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quot(dv_q), .rem(dv_r)
  );

  assign raw_ready = state == IDLE;
  assign res_valid = state == OUT;

  always_comb begin
    dv_start = 1'b0;
    dv_a = x;
    dv_b = y;
    unique case (state)
      EUC_GO: dv_start = y != '0;
      EUC_WAIT: if (dv_done && dv_r == '0) begin
        dv_start = 1'b1;
        dv_a = n;
        dv_b = y;
      end
      DN_WAIT: if (dv_done) begin
        dv_start = 1'b1;
        dv_a = d;
        dv_b = x;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: if (raw_valid) begin
          x <= raw.n;
          y <= raw.d;
          n <= raw.n;
          d <= raw.d;
          state <= EUC_GO;
        end
        EUC_GO: if (y == '0) begin
          if (x == '0) begin
            res <= '{res_num: '0, res_den: '0, zero_divisor: 1'b1};
            state <= OUT;
          end else begin
            res <= '{res_num: 32'sd1, res_den: '0, zero_divisor: 1'b0};
            state <= OUT;
          end
        end else begin
          state <= EUC_WAIT;
        end
        EUC_WAIT: if (dv_done) begin
          if (dv_r == '0) begin
            x <= y;
            state <= DN_WAIT;
          end else begin
            x <= y;
            y <= dv_r;
            state <= EUC_GO;
          end
        end
        DN_WAIT: if (dv_done) begin
          qn <= dv_q;
          state <= DD_WAIT;
        end
        DD_WAIT: if (dv_done) begin
          res <= '{res_num: qn, res_den: dv_q, zero_divisor: 1'b0};
          state <= OUT;
        end
        OUT: if (res_ready) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

@@ src/rational_mul_div_reduce.sv @@
// Top level: rational multiply/divide with reduction by Euclid's divisor.
// Depends on rmd_pkg, rmd_if, rmd_front, rmd_queue, rmd_back, rmd_divu.
//
//   channel   dir   payload
//   in_ch     in    op, a_num, a_den, b_num, b_den
//   out_ch    out   res_num, res_den, zero_divisor
//
// Front multiplies and registers the product pair; back runs Euclid on
// one shared 32-iteration radix-2 divider, one division per remainder
// step, then two final divisions by the common divisor it finds.
// Reset is synchronous; either side may stall, the queue holds up to
// QueueDepth product pairs while the back end is busy.
module rational_mul_div_reduce #(
  parameter int QueueDepth = rmd_pkg::QueueDepth
) (
  input logic clk,
  input logic rst,
  rmd_in_if.sink in_ch,
  rmd_out_if.source out_ch
);
  rmd_pkg::in_item_t in_item;
  rmd_pkg::raw_pair_t f_raw, q_raw;
  rmd_pkg::out_item_t res;
  logic f_valid, f_ready, q_valid, q_ready;

  assign in_item = '{op: in_ch.op, a_num: in_ch.a_num, a_den: in_ch.a_den,
                     b_num: in_ch.b_num, b_den: in_ch.b_den};

  rmd_front u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item,
    .raw_valid(f_valid), .raw_ready(f_ready), .raw(f_raw)
  );

  rmd_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_raw),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_raw)
  );

  rmd_back u_back (
    .clk, .rst, .raw_valid(q_valid), .raw_ready(q_ready), .raw(q_raw),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.res_num = res.res_num;
  assign out_ch.res_den = res.res_den;
  assign out_ch.zero_divisor = res.zero_divisor;
endmodule

@@ src/rmd_checker.sv @@
// Port-level checker for the rational multiply/divide block, with bind.
// Depends on rational_mul_div_reduce_assert.svh.
`include "rational_mul_div_reduce_assert.svh"
module rmd_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [31:0] res_num,
  input logic signed [31:0] res_den,
  input logic zero_divisor
);
  `RMD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `RMD_ASSERT_NEXT(a_num_hold, clk, rst, out_valid && !out_ready, $stable(res_num))
  `RMD_ASSERT_IMPL(a_zero_res, clk, rst, out_valid && zero_divisor, res_num == 0 && res_den == 0)
  `RMD_ASSERT_IMPL(a_rst_quiet, clk, 1'b0, $past(rst), !out_valid)
  `RMD_ASSERT_IMPL(a_rst_ready, clk, 1'b0, $past(rst), in_ready)
endmodule

bind rational_mul_div_reduce rmd_checker u_rmd_checker (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .res_num(out_ch.res_num), .res_den(out_ch.res_den),
  .zero_divisor(out_ch.zero_divisor)
);

@@ tb/tb_rational_mul_div_reduce.sv @@
// Testbench for rational_mul_div_reduce: multiply/divide of two fractions with reduction.
// Items go in and results come out over valid/ready channels, with random gaps and stalls.
// Depends on rmd_pkg, rmd_if and the RTL; results are checked against a built-in predictor or stored values.
module tb_rational_mul_div_reduce;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OpW = rmd_pkg::OpW;
  localparam int InW = rmd_pkg::InW;
  localparam int ResW = rmd_pkg::ResW;

  typedef struct {
    rmd_pkg::in_item_t itm;
    bit typed;
    rmd_pkg::out_item_t res;
  } stim_row_t;

  localparam int NumRandom = 1600;
  localparam int HoldStart = 200;
  localparam int HoldCycles = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmd_in_if in_ch (.clk(clk));
  rmd_out_if out_ch (.clk(clk));

  rational_mul_div_reduce uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  stim_row_t stim_rows[$];
  rmd_pkg::out_item_t expected_results[$];
  bit cur_typed = 1'b0;
  rmd_pkg::out_item_t cur_res = '0;
  int accepted = 0;
  int received = 0;
  int mismatches = 0;
  int n_mul = 0;
  int n_div = 0;
  int n_zero = 0;
  int n_inf = 0;
  bit stim_done = 1'b0;

  function automatic rmd_pkg::out_item_t reduce_ratio(rmd_pkg::in_item_t it);
    longint n, d, x, y, r;
    rmd_pkg::out_item_t o;
    if (it.op == rmd_pkg::OP_DIV) begin
      n = longint'(it.a_num) * longint'(it.b_den);
      d = longint'(it.a_den) * longint'(it.b_num);
    end else begin
      n = longint'(it.a_num) * longint'(it.b_num);
      d = longint'(it.a_den) * longint'(it.b_den);
    end
    x = n;
    y = d;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    o = '0;
    if (x == 0) begin
      o.zero_divisor = 1'b1;
    end else begin
      o.res_num = ResW'(n / x);
      o.res_den = ResW'(d / x);
    end
    return o;
  endfunction

  function automatic rmd_pkg::in_item_t make_item(logic [OpW-1:0] op, int an, int ad,
                                                  int bn, int bd);
    rmd_pkg::in_item_t it;
    it.op = op;
    it.a_num = InW'(an);
    it.a_den = InW'(ad);
    it.b_num = InW'(bn);
    it.b_den = InW'(bd);
    return it;
  endfunction

  task automatic add_row(logic [OpW-1:0] op, int an, int ad, int bn, int bd,
                         bit typed = 1'b0, int rn = 0, int rd = 0, bit zd = 1'b0);
    stim_row_t row;
    row.itm = make_item(op, an, ad, bn, bd);
    row.typed = typed;
    row.res.res_num = ResW'(rn);
    row.res.res_den = ResW'(rd);
    row.res.zero_divisor = zd;
    stim_rows.push_back(row);
  endtask

  function automatic int pick_edge();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic int fib(int k);
    int a, b, t;
    a = 0;
    b = 1;
    for (int i = 0; i < k; i++) begin
      t = a + b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic int rsign(int v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic rmd_pkg::in_item_t rand_item();
    logic [OpW-1:0] op;
    int k, f;
    op = $urandom_range(0, 1) ? rmd_pkg::OP_DIV : rmd_pkg::OP_MUL;
    case ($urandom_range(0, 9))
      0, 1: return make_item(op, $urandom, $urandom, $urandom, $urandom);
      2, 3, 4: return make_item(op, $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                                $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
      5: return make_item(op, pick_edge(), pick_edge(), pick_edge(), pick_edge());
      6: begin
        k = $urandom_range(5, 23);
        return make_item(op, rsign(fib(k + 1)), rsign(fib(k)), rsign(1), rsign(1));
      end
      7: begin
        k = $urandom_range(2, 12);
        return make_item(op, rsign(fib(k + 1)), rsign(fib(k)),
                         rsign(fib(k + 2)), rsign(fib(k + 1)));
      end
      8: begin
        f = $urandom_range(2, 180);
        return make_item(op, rsign(f * $urandom_range(0, 180)), rsign(f * $urandom_range(0, 180)),
                         rsign(f * $urandom_range(0, 180)), rsign(f * $urandom_range(0, 180)));
      end
      default: return make_item(op, $urandom_range(0, 1) ? 0 : $urandom,
                                $urandom_range(0, 1) ? 0 : $urandom,
                                $urandom_range(0, 1) ? 0 : $urandom,
                                $urandom_range(0, 1) ? 0 : $urandom);
    endcase
  endfunction

  initial begin
    #200_000_000;
    $display("timeout: accepted=%0d received=%0d pending=%0d",
             accepted, received, expected_results.size());
    $display("[rational_mul_div_reduce] ERROR");
    $finish;
  end

  // directed rows, then random items; all are sent in bursts
  initial begin
    int burst;
    in_ch.valid = 1'b0;
    in_ch.op = rmd_pkg::OP_MUL;
    in_ch.a_num = '0;
    in_ch.a_den = '0;
    in_ch.b_num = '0;
    in_ch.b_den = '0;
    add_row(rmd_pkg::OP_MUL, 0, 1, 0, 1, 1'b1, 0, 1, 1'b0);
    add_row(rmd_pkg::OP_DIV, 0, 0, 5, 0, 1'b1, 0, 0, 1'b1);
    add_row(rmd_pkg::OP_MUL, 1, 0, 1, 1, 1'b1, 1, 0, 1'b0);
    add_row(rmd_pkg::OP_MUL, -5, 0, 1, 1, 1'b1, 1, 0, 1'b0);
    add_row(rmd_pkg::OP_MUL, -32768, -32768, -32768, -32768, 1'b1, 1, 1, 1'b0);
    add_row(rmd_pkg::OP_DIV, -32768, 1, 32767, 1, 1'b1, 32768, -32767, 1'b0);
    add_row(rmd_pkg::OP_MUL, 32767, 32767, 32767, 32767, 1'b1, 1, 1, 1'b0);
    add_row(rmd_pkg::OP_MUL, 32767, -32768, -32768, 32767);
    add_row(rmd_pkg::OP_DIV, 32767, -32768, -32768, 32767);
    add_row(rmd_pkg::OP_DIV, -1, -1, -1, -1);
    add_row(rmd_pkg::OP_MUL, 6, -4, 10, 9);
    add_row(rmd_pkg::OP_DIV, -6, 4, 10, -9);
    add_row(rmd_pkg::OP_DIV, 3, 5, 0, 7);
    add_row(rmd_pkg::OP_MUL, 0, 3, 7, 2);
    add_row(rmd_pkg::OP_MUL, 28657, 17711, 1, 1);
    add_row(rmd_pkg::OP_DIV, -28657, 17711, 1, 1);
    add_row(rmd_pkg::OP_MUL, 12, 0, -7, 5);
    add_row(rmd_pkg::OP_DIV, 21845, -21846, 10922, -5461);
    for (int i = 0; i < NumRandom; i++) begin
      stim_row_t row;
      row.itm = rand_item();
      row.typed = 1'b0;
      row.res = '0;
      stim_rows.push_back(row);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    burst = $urandom_range(1, 12);
    foreach (stim_rows[i]) begin
      in_ch.valid <= 1'b1;
      in_ch.op <= stim_rows[i].itm.op;
      in_ch.a_num <= stim_rows[i].itm.a_num;
      in_ch.a_den <= stim_rows[i].itm.a_den;
      in_ch.b_num <= stim_rows[i].itm.b_num;
      in_ch.b_den <= stim_rows[i].itm.b_den;
      cur_typed <= stim_rows[i].typed;
      cur_res <= stim_rows[i].res;
      do @(posedge clk); while (!in_ch.ready);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    int cyc, hold_left, mode;
    if (rst) begin
      out_ch.ready <= 1'b0;
      cyc = 0;
      hold_left = 0;
      mode = 0;
    end else begin
      cyc++;
      if (cyc == HoldStart) hold_left = HoldCycles;
      if (cyc % 97 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= cyc[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    rmd_pkg::out_item_t res;
    rmd_pkg::in_item_t it;
    if (!rst && in_ch.valid && in_ch.ready) begin
      it.op = in_ch.op;
      it.a_num = in_ch.a_num;
      it.a_den = in_ch.a_den;
      it.b_num = in_ch.b_num;
      it.b_den = in_ch.b_den;
      res = cur_typed ? cur_res : reduce_ratio(it);
      expected_results.push_back(res);
      accepted++;
      if (it.op == rmd_pkg::OP_DIV) n_div++;
      else n_mul++;
      if (res.zero_divisor) n_zero++;
      else if (res.res_den == 0) n_inf++;
    end
  end

  always @(posedge clk) begin
    rmd_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      received++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: num=%0d den=%0d zd=%0b",
                   out_ch.res_num, out_ch.res_den, out_ch.zero_divisor);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.res_num !== want.res_num || out_ch.res_den !== want.res_den ||
            out_ch.zero_divisor !== want.zero_divisor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp num=%0d den=%0d zd=%0b, got num=%0d den=%0d zd=%0b",
                     received, want.res_num, want.res_den, want.zero_divisor,
                     out_ch.res_num, out_ch.res_den, out_ch.zero_divisor);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_results.size() == 0);
    repeat (3000) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_results.size());
    end
    $display("covered %0d items (%0d multiply, %0d divide), %0d zero-divisor, %0d zero-denominator",
             accepted, n_mul, n_div, n_zero, n_inf);
    $display("checked %0d results, %0d mismatches", received, mismatches);
    if (mismatches == 0) begin
      $display("[rational_mul_div_reduce] OK");
    end else begin
      $display("[rational_mul_div_reduce] ERROR");
    end
    $finish;
  end
endmodule
